// ===== rtl/lcd_pkg.sv =====
`default_nettype none

package lcd_pkg;

	// fixed field widths of the ports
	localparam int MASK_W   = 8;
	localparam int MAX_W    = 16;
	localparam int LOAD_W   = 16;
	localparam int DEST_W   = 3;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NONE      = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd3;

	// request kinds
	localparam logic MODE_DISPATCH = 1'b0;
	localparam logic MODE_DONE     = 1'b1;

	// selection policies
	localparam logic POLICY_LEAST = 1'b0;
	localparam logic POLICY_RR    = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX     = 2'd2;

	// outcome of the destination search
	typedef struct packed {
		logic              found;
		logic [DEST_W-1:0] pick;
	} sel_t;

endpackage

`default_nettype wire

// ===== rtl/least_connection_dispatcher.sv =====
`default_nettype none

// Least-connection dispatcher. Each request is either a dispatch (mode 0),
// which picks an enabled destination and, if its connection count is below
// max_conns, books a connection on it, or a completion (mode 1), which
// releases one connection on done_index, saturating at zero. The policy
// register selects fewest-connections (ties to the lowest index) or round
// robin from a rotating pointer. Exactly one result follows each request, in
// order: dest_index, a status (ok, full, none enabled, underflow) and the
// destination's count after the update. The block takes one request per
// clock while out_ready is high: a request is held in an input stage, the
// search and counter update are combinational and the result lands in an
// output register once that register is free; out_valid is driven from
// that register. The counters sit in
// flip-flops and are updated on the same edge that loads the result, so a
// request directly behind another sees its effect. Only destinations below
// eight can be enabled or completed, so at most eight counters are held
// whatever NUM_DEST is. Configuration writes are taken at any time but must
// only be issued while no request is in flight.
module least_connection_dispatcher #(
	parameter int NUM_DEST    = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcd_pkg::MAX_W-1:0]      cfg_data,
	// request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [lcd_pkg::DEST_W-1:0]     done_index,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lcd_pkg::DEST_W-1:0]     dest_index,
	output logic [lcd_pkg::STATUS_W-1:0]   status,
	output logic [lcd_pkg::LOAD_W-1:0]     load
);

	localparam int MASK_W = lcd_pkg::MASK_W;
	localparam int LOAD_W = lcd_pkg::LOAD_W;
	localparam int DEST_W = lcd_pkg::DEST_W;
	localparam int MAX_W  = lcd_pkg::MAX_W;
	// counters that can ever be touched
	localparam int SCAN   = (NUM_DEST < MASK_W) ? NUM_DEST : MASK_W;
	localparam int SEL_W  = $clog2(SCAN);
	localparam int PTR_W  = $clog2(NUM_DEST);
	localparam logic [COUNT_WIDTH-1:0] COUNT_CAP = '1;

	// configuration registers
	logic               policy_q;
	logic [MASK_W-1:0]  enabled_mask_q;
	logic [MAX_W-1:0]   max_conns_q;

	// state
	logic [COUNT_WIDTH-1:0] conn_count_q [SCAN];
	logic [PTR_W-1:0]       rr_ptr_q;

	// input stage
	logic               valid_s1;
	logic               mode_s1;
	logic [DEST_W-1:0]  done_s1;

	// result register
	logic                           out_valid_q;
	logic [DEST_W-1:0]              dest_q;
	logic [lcd_pkg::STATUS_W-1:0]   status_q;
	logic [LOAD_W-1:0]              load_q;

	logic               advance;
	logic               fire;
	lcd_pkg::sel_t      sel;

	// result and update for the request in the input stage
	logic [DEST_W-1:0]              res_dest;
	logic [lcd_pkg::STATUS_W-1:0]   res_status;
	logic [COUNT_WIDTH-1:0]         res_count;
	logic                           upd_en;
	logic [SEL_W-1:0]               upd_idx;
	logic [COUNT_WIDTH-1:0]         upd_val;
	logic                           rr_en;
	logic [PTR_W-1:0]               rr_next;

	// configuration is always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q       <= lcd_pkg::POLICY_LEAST;
			enabled_mask_q <= MASK_W'(255);
			max_conns_q    <= MAX_W'(5);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lcd_pkg::REG_POLICY:  policy_q       <= cfg_data[0];
				lcd_pkg::REG_ENABLED: enabled_mask_q <= cfg_data[MASK_W-1:0];
				lcd_pkg::REG_MAX:     max_conns_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// the result register frees up when empty or when its request is taken
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// hold the request in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			done_s1 <= done_index;
		end
	end

	lcd_select #(
		.NUM_DEST    (NUM_DEST),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_select (
		.policy  (policy_q),
		.enabled (enabled_mask_q[SCAN-1:0]),
		.rr_ptr  (rr_ptr_q),
		.counts  (conn_count_q),
		.sel     (sel)
	);

	// work out the result and the single counter update of this request
	always_comb begin
		logic [COUNT_WIDTH-1:0] cnt;
		res_dest   = '0;
		res_status = lcd_pkg::STATUS_OK;
		res_count  = '0;
		upd_en     = 1'b0;
		upd_idx    = '0;
		upd_val    = '0;
		rr_en      = 1'b0;
		rr_next    = '0;
		cnt        = '0;
		if (mode_s1 == lcd_pkg::MODE_DONE) begin
			res_dest = done_s1;
			if (int'(done_s1) >= NUM_DEST) begin
				res_status = lcd_pkg::STATUS_UNDERFLOW;
			end else begin
				upd_idx = SEL_W'(done_s1);
				cnt     = conn_count_q[upd_idx];
				if (cnt == '0) begin
					res_status = lcd_pkg::STATUS_UNDERFLOW;
				end else begin
					upd_en    = 1'b1;
					upd_val   = cnt - COUNT_WIDTH'(1);
					res_count = upd_val;
				end
			end
		end else if (!sel.found) begin
			res_status = lcd_pkg::STATUS_NONE;
		end else begin
			res_dest = sel.pick;
			upd_idx  = SEL_W'(sel.pick);
			cnt      = conn_count_q[upd_idx];
			// advance the pointer past the pick, accepted or not
			rr_en    = (policy_q == lcd_pkg::POLICY_RR);
			rr_next  = (int'(sel.pick) == NUM_DEST - 1) ? '0
				: PTR_W'(sel.pick) + PTR_W'(1);
			if (32'(cnt) < 32'(max_conns_q) && cnt != COUNT_CAP) begin
				upd_en    = 1'b1;
				upd_val   = cnt + COUNT_WIDTH'(1);
				res_count = upd_val;
			end else begin
				res_status = lcd_pkg::STATUS_FULL;
				res_count  = cnt;
			end
		end
	end

	// commit the counter and pointer on the same edge that loads the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SCAN; i++) begin
				conn_count_q[i] <= '0;
			end
			rr_ptr_q <= '0;
		end else if (fire) begin
			if (upd_en) begin
				conn_count_q[upd_idx] <= upd_val;
			end
			if (rr_en) begin
				rr_ptr_q <= rr_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dest_q   <= res_dest;
			status_q <= res_status;
			load_q   <= LOAD_W'(res_count);
		end
	end

	assign out_valid  = out_valid_q;
	assign dest_index = dest_q;
	assign status     = status_q;
	assign load       = load_q;

`ifndef SYNTHESIS
	// a blocked input means both stages are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q))
		else $error("input blocked with a free stage");

	// a counter update always comes with a result
	a_update_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && upd_en) |=> out_valid_q)
		else $error("counter updated without a result");

	// the pointer stays within the destination range
	a_rr_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(rr_ptr_q) < NUM_DEST)
		else $error("round-robin pointer out of range");

	// a successful dispatch never reports an empty destination
	a_dispatch_load: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && mode_s1 == lcd_pkg::MODE_DISPATCH && upd_en) |-> (upd_val != '0))
		else $error("dispatch booked a connection but count is zero");
`endif

endmodule

`default_nettype wire

// ===== rtl/lcd_select.sv =====
`default_nettype none

module lcd_select #(
	parameter int NUM_DEST    = 8,
	parameter int COUNT_WIDTH = 16,
	localparam int SCAN  = (NUM_DEST < lcd_pkg::MASK_W) ? NUM_DEST : lcd_pkg::MASK_W,
	localparam int PTR_W = $clog2(NUM_DEST)
) (
	input  logic                   policy,
	input  logic [SCAN-1:0]        enabled,
	input  logic [PTR_W-1:0]       rr_ptr,
	input  logic [COUNT_WIDTH-1:0] counts [SCAN],
	output lcd_pkg::sel_t          sel
);

	localparam int DEST_W = lcd_pkg::DEST_W;

	lcd_pkg::sel_t least_sel;
	lcd_pkg::sel_t rr_sel;
	logic [SCAN-1:0] upper;

	// fewest connections, strict compare keeps the lowest index on a tie
	always_comb begin
		logic [COUNT_WIDTH-1:0] best;
		best = '0;
		least_sel = '0;
		for (int i = 0; i < SCAN; i++) begin
			if (enabled[i] && (!least_sel.found || counts[i] < best)) begin
				best = counts[i];
				least_sel.found = 1'b1;
				least_sel.pick = DEST_W'(i);
			end
		end
	end

	// first enabled at or after the pointer, else wrap to the lowest enabled
	always_comb begin
		for (int i = 0; i < SCAN; i++) begin
			upper[i] = enabled[i] && (i >= int'(rr_ptr));
		end
	end

	always_comb begin
		rr_sel = '0;
		rr_sel.found = |enabled;
		for (int i = SCAN - 1; i >= 0; i--) begin
			if (enabled[i]) begin
				rr_sel.pick = DEST_W'(i);
			end
		end
		if (|upper) begin
			for (int i = SCAN - 1; i >= 0; i--) begin
				if (upper[i]) begin
					rr_sel.pick = DEST_W'(i);
				end
			end
		end
	end

	assign sel = (policy == lcd_pkg::POLICY_RR) ? rr_sel : least_sel;

endmodule

`default_nettype wire
